FILE: rtl/lfc_pkg.sv
// Shared types and constants for the long FIR convolver.
// No dependencies; used by long_fir_convolver_unit and lfc_checker.
package lfc_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TAP_IDX_W  = 10;
  localparam int unsigned TAP_CNT_W  = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned FRAC_BITS  = 15;

  // request operations
  localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 2'd1;

  localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/long_fir_convolver_unit.sv
// Long direct-form FIR convolver: tap and history memories, one shared MAC.
// Depends on lfc_pkg.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_valid / in_ready  | operation, sample_in, tap_index, tap_value
//  out_    | out | out_valid/out_ready  | sample_out
//  cfg_    | in  | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// A filter request passes through ST_MAC, once per tap in use (skipped when no taps
// are in use), then ST_DRAIN and ST_EMIT before in_ready goes high again;
// one tap and one history word are read per cycle through the single MAC.
// Bypassed filter requests go straight to ST_EMIT; load and clear never leave ST_IDLE.
// After reset the tap memory is swept to zero, one entry at a time, with in_ready low.
// A result waiting in the output register does not block new requests; only
// the result of the next filter request waits for it to drain.
module long_fir_convolver_unit #(
  parameter int unsigned MAX_TAPS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lfc_pkg::OP_W-1:0]              in_operation,
  input  logic signed [lfc_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  logic [lfc_pkg::TAP_IDX_W-1:0]         in_tap_index,
  input  logic signed [lfc_pkg::SAMPLE_W-1:0]   in_tap_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lfc_pkg::SAMPLE_W-1:0]   out_sample_out,
  input  logic                                  cfg_we,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lfc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import lfc_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_TAPS);
  localparam int unsigned CW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned PW    = 2 * SAMPLE_W;
  localparam int unsigned ACC_W = PW + CW;
  localparam int unsigned QW    = ACC_W - FRAC_BITS;

  // memories
  logic signed [SAMPLE_W-1:0] tap_mem  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];

  state_t state_r, state_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          byp_r, byp_nxt;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [TAP_CNT_W-1:0] tap_count_r;
  logic          bypass_r;

  logic                       v1_r, v2_r, hmask_r;
  logic signed [SAMPLE_W-1:0] tap_rd_r, hist_rd_r;
  logic signed [PW-1:0]       prod_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic in_acc, acc_filter, acc_load, acc_clear;
  logic issue, emit_load, tap_we;
  logic [AW-1:0] tap_waddr;
  logic signed [SAMPLE_W-1:0] tap_wdata;
  logic [CW-1:0] n_cap;
  logic          last_k;
  logic signed [ACC_W-1:0] rnd_sum;
  logic [QW-1:0]           q;
  logic                    q_in_range;
  logic signed [SAMPLE_W-1:0] result;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign acc_filter = in_acc && (in_operation == OP_FILTER);
  assign acc_load   = in_acc && (in_operation == OP_LOAD) &&
                      (32'(in_tap_index) < 32'(MAX_TAPS));
  assign acc_clear  = in_acc && (in_operation == OP_CLEAR);

  assign n_cap  = (32'(tap_count_r) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tap_count_r);
  assign last_k = (CW'(k_r) == n_r - CW'(1));

  // rounding: add half LSB, arithmetic shift, saturate
  assign rnd_sum    = acc_r + ACC_W'(1 << (FRAC_BITS - 1));
  assign q          = rnd_sum[ACC_W-1:FRAC_BITS];
  assign q_in_range = (&q[QW-1:SAMPLE_W-1]) || !(|q[QW-1:SAMPLE_W-1]);
  always_comb begin
    if (byp_r) begin
      result = x_r;
    end else if (q_in_range) begin
      result = q[SAMPLE_W-1:0];
    end else begin
      result = q[QW-1] ? SAT_NEG : SAT_POS;
    end
  end

  // next state and control
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    ptr_nxt   = ptr_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    byp_nxt   = byp_r;
    issue     = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        k_nxt = k_r + AW'(1);
        if (32'(k_r) == MAX_TAPS - 1) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc_filter) begin
          k_nxt   = '0;
          pos_nxt = ptr_r;
          n_nxt   = n_cap;
          byp_nxt = bypass_r;
          ptr_nxt = (32'(ptr_r) == MAX_TAPS - 1) ? '0 : ptr_r + AW'(1);
          if (32'(fill_r) != MAX_TAPS) begin
            fill_nxt = fill_r + CW'(1);
          end
          if (bypass_r) begin
            state_nxt = ST_EMIT;
          end else if (n_cap == '0) begin
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_MAC;
          end
        end else if (acc_clear) begin
          ptr_nxt  = '0;
          fill_nxt = '0;
        end
      end
      ST_MAC: begin
        issue   = 1'b1;
        k_nxt   = k_r + AW'(1);
        pos_nxt = (pos_r == '0) ? AW'(MAX_TAPS - 1) : pos_r - AW'(1);
        if (last_k) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase
  end

  // tap memory: zero sweep after reset, else tap loads
  assign tap_we    = (state_r == ST_SWEEP) || acc_load;
  assign tap_waddr = (state_r == ST_SWEEP) ? k_r : AW'(in_tap_index);
  assign tap_wdata = (state_r == ST_SWEEP) ? '0 : in_tap_value;

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    tap_rd_r <= tap_mem[k_r];
  end

  // history is written at accept, before the first read of this request
  always_ff @(posedge clk) begin
    if (acc_filter) begin
      hist_mem[ptr_r] <= in_sample_in;
    end
    hist_rd_r <= hist_mem[pos_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      k_r         <= '0;
      pos_r       <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      n_r         <= '0;
      byp_r       <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      tap_count_r <= TAP_CNT_W'(1);
      bypass_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pos_r       <= pos_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      n_r         <= n_nxt;
      byp_r       <= byp_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= emit_load || (out_valid_r && !out_ready);
      if (cfg_we && (cfg_index == CFG_TAP_COUNT)) begin
        tap_count_r <= cfg_wdata[TAP_CNT_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_BYPASS)) begin
        bypass_r <= cfg_wdata[0];
      end
    end
  end

  // MAC datapath; entries older than the fill count read as zero
  always_ff @(posedge clk) begin
    if (issue) begin
      hmask_r <= (CW'(k_r) < fill_r);
    end
    if (v1_r) begin
      prod_r <= hmask_r ? PW'(tap_rd_r) * PW'(hist_rd_r) : '0;
    end
    if (acc_filter) begin
      acc_r <= '0;
      x_r   <= in_sample_in;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (emit_load) begin
      out_sample_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

FILE: rtl/lfc_checker.sv
// Port-level checks for long_fir_convolver_unit, attached with bind.
// Depends on lfc_pkg.
module lfc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [lfc_pkg::OP_W-1:0]            in_operation,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [lfc_pkg::SAMPLE_W-1:0] out_sample_out
);
  import lfc_pkg::*;

  // tap sweep keeps the input closed right after reset
  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // a filter request leaves the block busy right after it is accepted
  a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_FILTER) |=> !in_ready)
    else $error("in_ready high right after a filter request");

  // load and clear finish in the accept cycle
  a_load_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_operation == OP_LOAD || in_operation == OP_CLEAR))
      |=> in_ready)
    else $error("in_ready low after a load or clear request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample_out)))
    else $error("output result dropped or changed while stalled");

endmodule

bind long_fir_convolver_unit lfc_checker u_lfc_checker (.*);

FILE: test/long_fir_convolver_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for long_fir_convolver_unit: directed and random filter, tap-load and clear
// requests, each result checked against a behavioral FIR model kept in this file.
// Depends on lfc_pkg and long_fir_convolver_unit.
module long_fir_convolver_unit_tb;
  import lfc_pkg::*;

  localparam int unsigned MAX_TAPS      = 1024;
  localparam int unsigned IDX_W         = $clog2(MAX_TAPS);
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd2;  // first index past the register map

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = OP_FILTER;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic [TAP_IDX_W-1:0] in_tap_index = '0;
  logic signed [SAMPLE_W-1:0] in_tap_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // FIR model state
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  int unsigned hist_wr_pos = 0;
  int unsigned taps_in_use = 1;
  logic pass_through = 1'b1;
  logic signed [SAMPLE_W-1:0] pending_samples [$];

  int errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 57;
  int unsigned recv_hold_left = 0;

  long_fir_convolver_unit #(.MAX_TAPS(MAX_TAPS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_sample_in(in_sample_in),
    .in_tap_index(in_tap_index),
    .in_tap_value(in_tap_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_out(out_sample_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** long_fir_convolver_unit: FAILED **");
      $finish;
    end
  end

  // result side: check each accepted result, then pick ready for the next cycle
  always @(posedge clk) begin : result_check
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result: sample_out %0d", out_sample_out);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_out !== want) begin
          $error("sample_out: expected %0d, got %0d", want, out_sample_out);
          errors++;
        end
      end
    end
    if (recv_hold_left > 0) begin
      out_ready <= 1'b0;
      recv_hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] fir_output(
      input logic signed [SAMPLE_W-1:0] x);
    longint acc;
    longint rounded;
    int unsigned n;
    int unsigned k;
    int unsigned pos;
    hist_mem[IDX_W'(hist_wr_pos)] = x;
    n = (taps_in_use > MAX_TAPS) ? MAX_TAPS : taps_in_use;
    acc = 0;
    for (k = 0; k < n; k++) begin
      pos = (hist_wr_pos + MAX_TAPS - k) % MAX_TAPS;
      acc += longint'(coef_mem[IDX_W'(k)]) * longint'(hist_mem[IDX_W'(pos)]);
    end
    hist_wr_pos = (hist_wr_pos + 1) % MAX_TAPS;
    if (pass_through) return x;
    // add half an LSB, then floor: ties go toward plus infinity
    rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (rounded > longint'($signed(SAT_POS))) return SAT_POS;
    if (rounded < longint'($signed(SAT_NEG))) return SAT_NEG;
    return SAMPLE_W'(rounded);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return SAT_POS;
      1: return SAT_NEG;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic model_request(input logic [OP_W-1:0] op,
                               input logic signed [SAMPLE_W-1:0] smp,
                               input logic [TAP_IDX_W-1:0] idx,
                               input logic signed [SAMPLE_W-1:0] coef);
    case (op)
      OP_FILTER: pending_samples.push_back(fir_output(smp));
      OP_LOAD:   coef_mem[idx] = coef;
      OP_CLEAR: begin
        foreach (hist_mem[i]) hist_mem[i] = '0;
        hist_wr_pos = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [SAMPLE_W-1:0] smp,
                              input logic [TAP_IDX_W-1:0] idx,
                              input logic signed [SAMPLE_W-1:0] coef);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_sample_in <= smp;
    in_tap_index <= idx;
    in_tap_value <= coef;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_request(op, smp, idx, coef);
  endtask

  task automatic send_filter(input logic signed [SAMPLE_W-1:0] smp);
    send_request(OP_FILTER, smp, TAP_IDX_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic load_tap(input logic [TAP_IDX_W-1:0] idx,
                          input logic signed [SAMPLE_W-1:0] coef);
    send_request(OP_LOAD, rand_sample(), idx, coef);
  endtask

  task automatic send_random(input int unsigned span);
    int unsigned pick;
    logic [TAP_IDX_W-1:0] idx;
    pick = $urandom_range(99);
    idx = ($urandom_range(3) == 0) ? TAP_IDX_W'($urandom) : TAP_IDX_W'($urandom_range(span - 1));
    if (pick < 75) send_filter(rand_sample());
    else if (pick < 95) load_tap(idx, rand_sample());
    else if (pick < 97) send_request(OP_CLEAR, rand_sample(), idx, rand_sample());
    else send_request(OP_RESERVED, rand_sample(), idx, rand_sample());
  endtask

  // let every result out, then give load/clear time to retire
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] count, input logic byp);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TAP_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    taps_in_use = 32'(count);
    cfg_index <= CFG_BYPASS;
    cfg_wdata <= CFG_DATA_W'(byp);
    @(posedge clk);
    pass_through = byp;
    // writes past the register map must not disturb anything
    cfg_index <= CFG_SPARE | CFG_IDX_W'($urandom_range(1));
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_bypass_after_reset();
    send_filter(SAT_POS);
    send_filter(SAT_NEG);
    send_filter(16'sd0);
    send_filter(-16'sd1);
  endtask

  task automatic test_tap_extremes();
    configure(11'd4, 1'b0);
    load_tap(10'd0, SAT_NEG);
    load_tap(10'd1, SAT_NEG);
    load_tap(10'd2, SAT_POS);
    load_tap(10'd3, SAT_POS);
    send_request(OP_RESERVED, rand_sample(), TAP_IDX_W'($urandom), rand_sample());
    // drives the sum into negative then positive saturation
    send_filter(SAT_POS);
    send_filter(SAT_POS);
    send_filter(SAT_NEG);
    send_filter(SAT_NEG);
  endtask

  task automatic test_clear_and_rounding();
    configure(11'd1, 1'b0);
    send_request(OP_CLEAR, rand_sample(), TAP_IDX_W'($urandom), rand_sample());
    load_tap(10'd0, 16'sd16384);
    send_filter(16'sd1);
    send_filter(-16'sd1);
    send_filter(-16'sd3);
  endtask

  task automatic test_tap_count_extremes();
    configure(11'd0, 1'b0);
    send_filter(rand_sample());
    send_filter(rand_sample());
    load_tap('1, SAT_POS);
    configure('1, 1'b0);  // clamps to MAX_TAPS
    send_filter(rand_sample());
  endtask

  task automatic test_random_traffic(input int unsigned items, input int unsigned lo,
                                     input int unsigned hi, input int unsigned s_pct,
                                     input int unsigned r_pct);
    int unsigned sent;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    configure(CFG_DATA_W'(hi), 1'b0);
    for (sent = 0; sent < hi; sent++) load_tap(TAP_IDX_W'(sent), rand_sample());
    while (sent < items) begin
      if (sent % 40 == 0) configure(CFG_DATA_W'($urandom_range(hi, lo)), $urandom_range(3) == 0);
      send_random(hi);
      sent++;
    end
  endtask

  task automatic test_full_length();
    int unsigned k;
    configure(CFG_DATA_W'(MAX_TAPS), 1'b0);
    for (k = 0; k < 16; k++) begin
      if (k % 4 == 0) load_tap(TAP_IDX_W'($urandom), rand_sample());
      else send_filter(rand_sample());
    end
  endtask

  task automatic test_backpressure();
    int unsigned k;
    configure(11'd3, 1'b0);
    recv_hold_left = 300;
    for (k = 0; k < 30; k++) send_filter(rand_sample());
    drain();
  endtask

  initial begin
    foreach (hist_mem[i]) hist_mem[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_bypass_after_reset();
    test_tap_extremes();
    test_clear_and_rounding();
    test_tap_count_extremes();
    test_random_traffic(180, 1, 16, 18, 57);
    test_random_traffic(180, 17, 64, 57, 18);
    test_random_traffic(180, 1, 8, 0, 0);
    test_full_length();
    test_backpressure();
    drain();
    if (errors == 0) $display("** long_fir_convolver_unit: PASSED **");
    else $display("** long_fir_convolver_unit: FAILED **");
    $finish;
  end

endmodule
